// ===== hw/rtl/apbpg_pkg.sv =====
// shared types and constants for the audio playout buffer with prefill gate
// no dependencies; every other file of the block refers to this package

package apbpg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 13;
   localparam int FILL_W   = 13;
   localparam int CLOCK_W  = 48;
   localparam int ACTION_W = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // register word index
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_STARTUP = 1'b0;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PULL  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic signed [SAMPLE_W-1:0] pcm_sample;
      logic                       first_of_block;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       from_queue;
      logic                       playing;
      logic [FILL_W-1:0]          fill_level;
      logic [CLOCK_W-1:0]         consumed_count;
      logic                       overflow;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic push;
      logic pull;
      logic clear;
   } cmd_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEND
   } state_type;

endpackage

// ===== hw/rtl/apbpg_req_if.sv =====
// request channel: valid/ready handshake carrying one request payload
// depends on apbpg_pkg for the payload struct

interface apbpg_req_if;
   logic                       valid;
   logic                       ready;
   apbpg_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/apbpg_rsp_if.sv =====
// result channel: valid/ready handshake carrying one result payload
// depends on apbpg_pkg for the payload struct

interface apbpg_rsp_if;
   logic                       valid;
   logic                       ready;
   apbpg_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/apbpg_csr.sv =====
// apb register block holding the prefill watermark
// depends on apbpg_pkg for widths and the register index

module apbpg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apbpg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [apbpg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [apbpg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [apbpg_pkg::CFG_W-1:0]         startup_samples
);

   logic [apbpg_pkg::CFG_W-1:0]     startup_ff;
   logic [apbpg_pkg::CFG_W-1:0]     startup_in;
   logic [apbpg_pkg::CSR_IDX_W-1:0] word_idx;
   logic                            wr_en;

   assign word_idx   = csr_paddr[apbpg_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      startup_in = startup_ff;
      if (wr_en && word_idx == apbpg_pkg::CSR_IDX_STARTUP) begin
         startup_in = csr_pwdata[apbpg_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_ff <= '0;
      end else begin
         startup_ff <= startup_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (word_idx == apbpg_pkg::CSR_IDX_STARTUP) begin
         csr_prdata = apbpg_pkg::CSR_DATA_W'(startup_ff);
      end
   end

   assign startup_samples = startup_ff;

endmodule

// ===== hw/rtl/apbpg_ctrl.sv =====
// controller: takes one request, issues datapath commands, holds the result until taken
// depends on apbpg_pkg for the state enum, command struct and action codes

module apbpg_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [apbpg_pkg::ACTION_W-1:0]    req_action,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output apbpg_pkg::cmd_type                cmd
);

   apbpg_pkg::state_type state_ff;
   apbpg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apbpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         apbpg_pkg::ST_IDLE: begin
            // no request is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               case (req_action)
                  apbpg_pkg::ACT_PUSH:  cmd.push  = 1'b1;
                  apbpg_pkg::ACT_PULL:  cmd.pull  = 1'b1;
                  apbpg_pkg::ACT_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
               state_in = apbpg_pkg::ST_SEND;
            end
         end
         apbpg_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = apbpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apbpg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/apbpg_dpath.sv =====
// datapath: sample memory, pointers, fill count, prefill gate, sample clock, result register
// depends on apbpg_pkg for payload structs and the command struct

module apbpg_dpath #(
   parameter int FIFO_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  apbpg_pkg::cmd_type              cmd,
   input  apbpg_pkg::req_payload_type      req,
   input  logic [apbpg_pkg::CFG_W-1:0]     startup_samples,
   output apbpg_pkg::rsp_payload_type      rsp
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W = (CNT_W > apbpg_pkg::CFG_W) ? CNT_W : apbpg_pkg::CFG_W;

   logic [apbpg_pkg::SAMPLE_W-1:0] mem [FIFO_DEPTH];

   logic [PTR_W-1:0]                  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]                  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]                  fill_ff, fill_in;
   logic                              gate_ff, gate_in;
   logic                              muted_ff, muted_in;
   logic [apbpg_pkg::CLOCK_W-1:0]     clock_ff, clock_in;

   logic signed [apbpg_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                              from_q_ff;
   logic                              playing_ff;
   logic [apbpg_pkg::FILL_W-1:0]      fill_lvl_ff;
   logic [apbpg_pkg::CLOCK_W-1:0]     consumed_ff;
   logic                              ovf_ff;

   logic                              full;
   logic                              take;
   logic                              ovf;
   logic                              mem_we;
   logic [CMP_W-1:0]                  fill_cmp;
   logic [CMP_W-1:0]                  start_cmp;

   assign full      = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign fill_cmp  = CMP_W'(fill_ff);
   assign start_cmp = CMP_W'(startup_samples);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      gate_in   = gate_ff;
      muted_in  = muted_ff;
      clock_in  = clock_ff;
      take      = 1'b0;
      ovf       = 1'b0;
      mem_we    = 1'b0;
      if (cmd.clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         fill_in   = '0;
         gate_in   = 1'b0;
         muted_in  = 1'b0;
         clock_in  = '0;
      end else if (cmd.push) begin
         if (!full) begin
            mem_we    = 1'b1;
            wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
            fill_in   = fill_ff + 1'b1;
         end else begin
            ovf = 1'b1;
         end
      end else if (cmd.pull) begin
         // gate is checked only at the start of an output block
         if (req.first_of_block) begin
            if (startup_samples != '0 && !gate_ff) begin
               if (fill_cmp < start_cmp) begin
                  muted_in = 1'b1;
               end else begin
                  gate_in  = 1'b1;
                  muted_in = 1'b0;
               end
            end else begin
               muted_in = 1'b0;
            end
         end
         if (!muted_in && fill_ff != '0) begin
            take      = 1'b1;
            rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            fill_in   = fill_ff - 1'b1;
            clock_in  = clock_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         gate_ff   <= 1'b0;
         muted_ff  <= 1'b0;
         clock_ff  <= '0;
      end else if (cmd.load) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         gate_ff   <= gate_in;
         muted_ff  <= muted_in;
         clock_ff  <= clock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= req.pcm_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // result register, loaded with the state after this request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         from_q_ff   <= take;
         playing_ff  <= gate_in || (startup_samples == '0);
         fill_lvl_ff <= apbpg_pkg::FILL_W'(fill_in);
         consumed_ff <= clock_in;
         ovf_ff      <= ovf;
      end
   end

   always_comb begin
      rsp.out_sample     = from_q_ff ? rd_data_ff : '0;
      rsp.from_queue     = from_q_ff;
      rsp.playing        = playing_ff;
      rsp.fill_level     = fill_lvl_ff;
      rsp.consumed_count = consumed_ff;
      rsp.overflow       = ovf_ff;
   end

endmodule

// ===== hw/rtl/audio_playout_buffer_prefill_gate_core.sv =====
// audio playout buffer with prefill gate, top level
// depends on apbpg_pkg, apbpg_req_if, apbpg_rsp_if, apbpg_csr, apbpg_ctrl, apbpg_dpath
//
// requests arrive on req_chan: push a 16-bit pcm sample, pull one output
// sample, or clear the buffer state. every request gives exactly one result
// on rsp_chan with the pulled q1.15 sample, the gate status, the fill level,
// the 48-bit sample clock and the overflow flag for a dropped push. the watermark
// (startup_samples, apb word 0): the user must write it only while idle; unchecked.
//
// one request is in flight at a time: req_chan.ready is high only while idle
// and the result is valid the cycle after acceptance. the single-port sample
// memory read is registered. while the receiver stalls the result is held and
// no new request is taken.
// reset empties the buffer, clears the sample clock and watermark, closes the
// gate; the sample memory itself is not cleared and no clearing pass runs.

module audio_playout_buffer_prefill_gate_core #(
   parameter int FIFO_DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   apbpg_req_if.sink                           req_chan,
   apbpg_rsp_if.source                         rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apbpg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [apbpg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [apbpg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic [apbpg_pkg::CFG_W-1:0]  startup_samples;
   apbpg_pkg::cmd_type           cmd;
   apbpg_pkg::rsp_payload_type   rsp_payload;
   logic                         req_ready;
   logic                         rsp_valid;

   apbpg_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .startup_samples (startup_samples)
   );

   apbpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.payload.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd)
   );

   apbpg_dpath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req             (req_chan.payload),
      .startup_samples (startup_samples),
      .rsp             (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // an accepted request shows its result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready |=> rsp_valid)
      else $error("result missing after accepted request");

   // no new request is taken while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   // a sample cannot be both played and a dropped push
   a_pull_push_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.from_queue && rsp_payload.overflow))
      else $error("result marks both played sample and overflow");

endmodule
